// ===== rtl/wof_pkg.sv =====
// Shared types, constants and the difference test for the window outlier filter.
package wof_pkg;

    localparam int DataW    = 32;
    localparam int ThrW     = 31;
    localparam int KeepMin  = 2;
    localparam int AddrW    = 3;
    localparam int ApbDataW = 32;

    localparam logic [ThrW-1:0] ThrReset = ThrW'(1000);

    // register index codes (byte address bits above the word offset)
    localparam logic [AddrW-3:0] RegThreshold = 1'b0;

    typedef logic signed [DataW-1:0] t_sample;

    typedef struct packed {
        logic signed [DataW-1:0] value;
        logic                    kept;
        logic                    eos;
    } t_result;

    // true when |a - b| > thr, formed at DataW+1 bits
    function automatic logic exceeds(input t_sample a, input t_sample b,
                                     input logic [ThrW-1:0] thr);
        logic signed [DataW:0] d;
        logic [DataW:0]        mag;
        d   = {a[DataW-1], a} - {b[DataW-1], b};
        mag = d[DataW] ? (DataW+1)'(-d) : d;
        return mag > {2'b00, thr};
    endfunction

endpackage

// ===== rtl/wof_in_if.sv =====
// Sample input channel: valid/ready with one sample word.
interface wof_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [wof_pkg::DataW-1:0] sample_value;
    logic                             last_of_set;

    modport source (output valid, output sample_value, output last_of_set, input ready);
    modport sink (input valid, input sample_value, input last_of_set, output ready);
endinterface

// ===== rtl/wof_out_if.sv =====
// Decision output channel: valid/ready with one decided word.
interface wof_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [wof_pkg::DataW-1:0] decided_value;
    logic                             kept;
    logic                             end_of_set;

    modport source (output valid, output decided_value, output kept, output end_of_set,
                    input ready);
    modport sink (input valid, input decided_value, input kept, input end_of_set,
                  output ready);
endinterface

// ===== rtl/wof_span_eval.sv =====
// Neighbor difference count and keep decision for every candidate of the span.
module wof_span_eval #(
    parameter int WINDOW_REACH = 3
) (
    input  logic signed [wof_pkg::DataW-1:0] i_span [2*WINDOW_REACH+1],
    input  logic [$clog2(2*WINDOW_REACH+1)-1:0] i_seen,
    input  logic [wof_pkg::ThrW-1:0]         i_thr,
    output logic [WINDOW_REACH:0]            o_keep
);
    import wof_pkg::*;

    localparam int Hist  = 2 * WINDOW_REACH;
    localparam int SeenW = $clog2(Hist + 1);

    for (genvar c = 0; c <= WINDOW_REACH; c++) begin : g_cand
        logic [Hist-1:0] nb;
        for (genvar d = 1; d <= WINDOW_REACH; d++) begin : g_dist
            assign nb[d-1] = (i_seen >= SeenW'(WINDOW_REACH - c + d))
                           & exceeds(i_span[WINDOW_REACH+c], i_span[WINDOW_REACH+c-d], i_thr);
            if (c + d <= WINDOW_REACH) begin : g_right
                assign nb[WINDOW_REACH+d-1] =
                    exceeds(i_span[WINDOW_REACH+c], i_span[WINDOW_REACH+c+d], i_thr);
            end else begin : g_none
                assign nb[WINDOW_REACH+d-1] = 1'b0;
            end
        end
        assign o_keep[c] = $countones(nb) >= KeepMin;
    end

endmodule

// ===== rtl/window_outlier_filter_unit.sv =====
// Top level of the window outlier filter: window, decision and output queue.
//
// Samples enter on i_in, one word per cycle while i_in.ready is high, last_of_set
// marking the end of a set. Each sample is decided once WINDOW_REACH later samples
// of its set have arrived, or when its set ends; each decision leaves on o_out as
// one word carrying the value, the kept flag and end_of_set.
// A word accepted on i_in is held in the input register; the decisions it triggers
// are registered into the output queue, which drives o_out.
// Throughput: one word per cycle in both directions while o_out.ready is high. The
// final word of a set loads up to WINDOW_REACH+1 decisions at once; they leave one
// per cycle while o_out.ready is high, and i_in.ready stays low while the input
// register holds a word and more than one of them is still queued.
// When o_out stalls, the input register still takes one more word, then i_in.ready
// drops until the queue drains.
// Reset empties the window, the input register and the output queue, and sets the
// threshold to 1000. The user writes the threshold over the APB port (register 0,
// address 0) only while the block is idle (unenforced); pready is always high.
module window_outlier_filter_unit #(
    parameter int WINDOW_REACH = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wof_in_if.sink                        i_in,
    wof_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wof_pkg::AddrW-1:0]     paddr,
    input  logic [wof_pkg::ApbDataW-1:0]  pwdata,
    output logic [wof_pkg::ApbDataW-1:0]  prdata,
    output logic                          pready
);
    import wof_pkg::*;

    localparam int Hist  = 2 * WINDOW_REACH;
    localparam int NCand = WINDOW_REACH + 1;
    localparam int SeenW = $clog2(Hist + 1);
    localparam int CntW  = $clog2(NCand + 1);
    localparam int CIdxW = $clog2(NCand);

    logic [ThrW-1:0]  r_thr;
    logic             r_in_vld;
    t_sample          r_in_val;
    logic             r_in_last;
    t_sample          r_win [Hist];
    logic [SeenW-1:0] r_seen;
    t_result          r_q [NCand];
    logic [CntW-1:0]  r_q_cnt;

    t_sample          span [Hist+1];
    logic [NCand-1:0] keep_c;
    logic             q_free;
    logic             adv;
    logic             pop;
    logic             cfg_wr;
    logic [CntW-1:0]  bat_n;
    logic [CntW-1:0]  bat_off;
    t_result          n_q [NCand];
    logic [CntW-1:0]  n_q_cnt;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[AddrW-1:2] == RegThreshold);
    assign prdata = (paddr[AddrW-1:2] == RegThreshold) ? {1'b0, r_thr} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ThrReset;
        end else if (cfg_wr) begin
            r_thr <= pwdata[ThrW-1:0];
        end
    end

    // input register
    assign pop        = o_out.valid & o_out.ready;
    assign q_free     = (r_q_cnt == '0) || ((r_q_cnt == CntW'(1)) && o_out.ready);
    assign adv        = r_in_vld & q_free;
    assign i_in.ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_val  <= i_in.sample_value;
            r_in_last <= i_in.last_of_set;
        end
    end

    // span: history oldest first, newest sample at the top
    always_comb begin
        for (int i = 0; i < Hist; i++) begin
            span[i] = r_win[i];
        end
        span[Hist] = r_in_val;
    end

    wof_span_eval #(
        .WINDOW_REACH (WINDOW_REACH)
    ) u_eval (
        .i_span (span),
        .i_seen (r_seen),
        .i_thr  (r_thr),
        .o_keep (keep_c)
    );

    // window update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (adv) begin
            if (r_in_last) begin
                r_seen <= '0;
            end else if (r_seen != SeenW'(Hist)) begin
                r_seen <= r_seen + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < Hist; i++) begin
                r_win[i] <= span[i+1];
            end
        end
    end

    // batch size and first candidate
    always_comb begin
        if (r_in_last) begin
            bat_n = (r_seen >= SeenW'(WINDOW_REACH)) ? CntW'(NCand) : CntW'(r_seen + 1'b1);
        end else begin
            bat_n = (r_seen >= SeenW'(WINDOW_REACH)) ? CntW'(1) : '0;
        end
        bat_off = r_in_last ? CntW'(NCand) - bat_n : '0;
    end

    // output queue: drain from entry 0, reload with a whole batch
    always_comb begin
        logic [CntW-1:0]  sel;
        logic [CIdxW-1:0] idx;
        n_q     = r_q;
        n_q_cnt = r_q_cnt;
        sel     = '0;
        idx     = '0;
        if (pop) begin
            for (int e = 0; e < NCand - 1; e++) begin
                n_q[e] = r_q[e+1];
            end
            n_q_cnt = r_q_cnt - 1'b1;
        end
        if (adv) begin
            for (int e = 0; e < NCand; e++) begin
                sel = bat_off + CntW'(e);
                idx = (CntW'(e) < bat_n) ? sel[CIdxW-1:0] : '0;
                n_q[e].value = span[WINDOW_REACH + int'(idx)];
                n_q[e].kept  = keep_c[idx];
                n_q[e].eos   = r_in_last && (CntW'(e + 1) == bat_n);
            end
            n_q_cnt = bat_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= '0;
        end else begin
            r_q_cnt <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_out.valid         = r_q_cnt != '0;
    assign o_out.decided_value = r_q[0].value;
    assign o_out.kept          = r_q[0].kept;
    assign o_out.end_of_set    = r_q[0].eos;

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= CntW'(NCand))
        else $error("output queue count out of range");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SeenW'(Hist))
        else $error("window fill out of range");

    a_set_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_last |=> r_seen == '0)
        else $error("window not emptied after end of set");

    a_eos_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.end_of_set |-> r_q_cnt == CntW'(1))
        else $error("end of set word is not the last queued word");

endmodule
